### hdl/rbst_pkg.sv
package rbst_pkg;

	localparam int unsigned NUM_DIV  = 6;
	localparam int unsigned QW       = 49;
	localparam int unsigned TW       = 51;
	localparam int unsigned CFG_AW   = 3;

	localparam logic signed [TW-1:0] T_INF = TW'(51'sd1 <<< (QW));

	typedef enum logic [CFG_AW-1:0] {
		REG_MIN_X = 3'd0,
		REG_MIN_Y = 3'd1,
		REG_MIN_Z = 3'd2,
		REG_MAX_X = 3'd3,
		REG_MAX_Y = 3'd4,
		REG_MAX_Z = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [2:0] dzero;
		logic [2:0] in_box;
		logic [NUM_DIV-1:0] qneg;
	} side_t;

	typedef struct packed {
		logic [31:0] rem;
		logic [QW-1:0] nq;
	} div_st_t;

	// one restoring step: shift in the next dividend bit, subtract if it fits
	function automatic div_st_t div_step(input div_st_t cur, input logic [31:0] den);
		logic [32:0] sh;
		logic [32:0] df;
		div_st_t nx;
		sh = {cur.rem, cur.nq[QW-1]};
		df = sh - {1'b0, den};
		if (sh >= {1'b0, den}) begin
			nx.rem = df[31:0];
			nx.nq  = {cur.nq[QW-2:0], 1'b1};
		end else begin
			nx.rem = sh[31:0];
			nx.nq  = {cur.nq[QW-2:0], 1'b0};
		end
		return nx;
	endfunction

	function automatic logic [31:0] sat32(input logic signed [TW-1:0] t);
		logic [31:0] r;
		if (t < -TW'(52'sd2147483648))
			r = 32'h8000_0000;
		else if (t > TW'(52'sd2147483647))
			r = 32'h7fff_ffff;
		else
			r = t[31:0];
		return r;
	endfunction

endpackage

### hdl/ray_box_slab_test_core.sv
// channel   | dir | handshake            | payload
// s_*       | in  | s_tvalid / s_tready  | s_tdata: origin_x,y,z, dir_x,y,z (32b each)
// m_*       | out | m_tvalid / m_tready  | m_tdata: hit, t_entry, t_exit, zero pad
// cfg_*     | in  | cfg_we               | cfg_addr = register index, cfg_wdata
//
// One item per cycle sustained, as long as m_tready does not stall the output.
// Pipeline depth is set by the six parallel restoring dividers, one quotient bit per stage.
// The whole pipeline advances together whenever the output register is empty or taken,
// so a stall on m_tready holds every stage and drops nothing.
// Reset clears all valid bits and the box registers to zero.
module ray_box_slab_test_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [191:0] s_tdata,   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [71:0]  m_tdata,   // hit, t_entry, t_exit, 7 bits zero
	input  logic         cfg_we,
	input  logic [rbst_pkg::CFG_AW-1:0] cfg_addr,
	input  logic [31:0]  cfg_wdata
);
	import rbst_pkg::*;

	logic signed [31:0] box_q [NUM_DIV];
	logic adv;
	logic signed [31:0] org [3];
	logic signed [31:0] dir [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_DIV; i++) box_q[i] <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_MIN_X: box_q[0] <= cfg_wdata;
				REG_MIN_Y: box_q[1] <= cfg_wdata;
				REG_MIN_Z: box_q[2] <= cfg_wdata;
				REG_MAX_X: box_q[3] <= cfg_wdata;
				REG_MAX_Y: box_q[4] <= cfg_wdata;
				REG_MAX_Z: box_q[5] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	logic out_valid_q;
	assign adv      = !out_valid_q || m_tready;
	assign s_tready = adv;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			org[i] = s_tdata[32*i +: 32];
			dir[i] = s_tdata[32*(i+3) +: 32];
		end
	end

	// stage 1: corner minus origin, zero-direction slab check
	logic signed [32:0] diff_s1 [NUM_DIV];
	logic signed [31:0] dir_s1 [3];
	logic [2:0] dz_s1, in_s1;
	logic v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NUM_DIV; k++)
				diff_s1[k] <= 33'(box_q[k]) - 33'(org[k % 3]);
			for (int i = 0; i < 3; i++) begin
				dir_s1[i] <= dir[i];
				dz_s1[i]  <= (dir[i] == '0);
				in_s1[i]  <= (org[i] >= box_q[i] && org[i] <= box_q[i+3]) ||
				             (org[i] >= box_q[i+3] && org[i] <= box_q[i]);
			end
		end
	end

	// stage 2: magnitudes and quotient signs
	div_st_t dv_st [NUM_DIV][0:QW];
	logic [31:0] dv_den [NUM_DIV][0:QW];
	side_t dv_side [0:QW];
	logic dv_v [0:QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv_v[0] <= 1'b0;
		else if (adv) dv_v[0] <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NUM_DIV; k++) begin
				logic [32:0] mag;
				mag = diff_s1[k][32] ? 33'(-diff_s1[k]) : 33'(diff_s1[k]);
				dv_st[k][0].rem <= '0;
				dv_st[k][0].nq  <= {mag, 16'h0000};
				dv_den[k][0] <= dir_s1[k % 3][31] ? 32'(-dir_s1[k % 3]) : 32'(dir_s1[k % 3]);
				dv_side[0].qneg[k] <= diff_s1[k][32] ^ dir_s1[k % 3][31];
			end
			dv_side[0].dzero  <= dz_s1;
			dv_side[0].in_box <= in_s1;
		end
	end

	// divider stages, one quotient bit each
	for (genvar j = 1; j <= QW; j++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v[j] <= 1'b0;
			else if (adv) dv_v[j] <= dv_v[j-1];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				for (int k = 0; k < NUM_DIV; k++) begin
					dv_st[k][j]  <= div_step(dv_st[k][j-1], dv_den[k][j-1]);
					dv_den[k][j] <= dv_den[k][j-1];
				end
				dv_side[j] <= dv_side[j-1];
			end
		end
	end

	// stage 3: signed quotients
	logic signed [TW-1:0] tq_s3 [NUM_DIV];
	logic [2:0] dz_s3, in_s3;
	logic v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= dv_v[QW];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NUM_DIV; k++) begin
				logic signed [TW-1:0] q;
				q = $signed({2'b00, dv_st[k][QW].nq});
				tq_s3[k] <= dv_side[QW].qneg[k] ? -q : q;
			end
			dz_s3 <= dv_side[QW].dzero;
			in_s3 <= dv_side[QW].in_box;
		end
	end

	// stage 4: ordered slab interval per axis
	logic signed [TW-1:0] t0_s4 [3];
	logic signed [TW-1:0] t1_s4 [3];
	logic [2:0] ok_s4;
	logic v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (adv) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				if (dz_s3[i]) begin
					t0_s4[i] <= -T_INF;
					t1_s4[i] <= T_INF;
					ok_s4[i] <= in_s3[i];
				end else begin
					ok_s4[i] <= 1'b1;
					if (tq_s3[i] > tq_s3[i+3]) begin
						t0_s4[i] <= tq_s3[i+3];
						t1_s4[i] <= tq_s3[i];
					end else begin
						t0_s4[i] <= tq_s3[i];
						t1_s4[i] <= tq_s3[i+3];
					end
				end
			end
		end
	end

	// stage 5: intersect the three intervals
	logic signed [TW-1:0] ent_s5, ext_s5;
	logic ok_s5, v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (adv) v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			logic signed [TW-1:0] e01, x01;
			e01 = (t0_s4[0] > t0_s4[1]) ? t0_s4[0] : t0_s4[1];
			x01 = (t1_s4[0] < t1_s4[1]) ? t1_s4[0] : t1_s4[1];
			ent_s5 <= (e01 > t0_s4[2]) ? e01 : t0_s4[2];
			ext_s5 <= (x01 < t1_s4[2]) ? x01 : t1_s4[2];
			ok_s5  <= &ok_s4;
		end
	end

	// output register: hit test and saturation
	logic hit_q;
	logic [31:0] ent_q, ext_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (adv) out_valid_q <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (ok_s5 && ent_s5 <= ext_s5) begin
				hit_q <= 1'b1;
				ent_q <= sat32(ent_s5);
				ext_q <= sat32(ext_s5);
			end else begin
				hit_q <= 1'b0;
				ent_q <= '0;
				ext_q <= '0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, ext_q, ent_q, hit_q};

endmodule

### tb/sv/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rbst_pkg::*;

	typedef struct packed {
		logic [31:0] dz, dy, dx, oz, oy, ox;
	} ray_t;

	typedef struct {
		logic        hit;
		logic [31:0] t_entry;
		logic [31:0] t_exit;
	} isect_t;

	localparam longint T_BIG    = 64'sd1 <<< 62;
	localparam longint Q_LO     = -(64'sd1 <<< 31);
	localparam longint Q_HI     = (64'sd1 <<< 31) - 1;
	localparam int     IDLE_LIM = 20000;
	localparam int     LATENCY  = 55;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [191:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [71:0]  m_tdata;
	logic         cfg_we;
	cfg_reg_t     cfg_addr;
	logic [31:0]  cfg_wdata;

	ray_t   ray_q[$];
	isect_t isect_q[$];
	longint box_lo[3];
	longint box_hi[3];
	int     n_err;
	int     idle_cnt;
	int     src_gap;
	int     snk_gap;
	bit     quiet_snk;
	bit     quiet_src;

	ray_box_slab_test_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] clamp_q(longint t);
		if (t < Q_LO) t = Q_LO;
		if (t > Q_HI) t = Q_HI;
		return t[31:0];
	endfunction

	function automatic isect_t slab_isect(ray_t r);
		isect_t res;
		longint o, d, a, b, lo, hi, enter, leave;
		bit     ok;
		logic [31:0] org[3];
		logic [31:0] dir[3];
		org = '{r.ox, r.oy, r.oz};
		dir = '{r.dx, r.dy, r.dz};
		enter = -T_BIG;
		leave = T_BIG;
		ok = 1'b1;
		for (int i = 0; i < 3; i++) begin
			o = longint'(signed'(org[i]));
			d = longint'(signed'(dir[i]));
			if (d == 0) begin
				lo = box_lo[i] < box_hi[i] ? box_lo[i] : box_hi[i];
				hi = box_lo[i] < box_hi[i] ? box_hi[i] : box_lo[i];
				if (o < lo || o > hi) begin
					ok = 1'b0;
					break;
				end
				a = -T_BIG;
				b = T_BIG;
			end else begin
				a = ((box_lo[i] - o) * 65536) / d;
				b = ((box_hi[i] - o) * 65536) / d;
				if (a > b) begin
					lo = a; a = b; b = lo;
				end
			end
			if (a > enter) enter = a;
			if (b < leave) leave = b;
		end
		if (ok && enter > leave) ok = 1'b0;
		res.hit     = ok;
		res.t_entry = ok ? clamp_q(enter) : 32'd0;
		res.t_exit  = ok ? clamp_q(leave) : 32'd0;
		return res;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [31:0] pick_val();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'd0;
			3: return $urandom();
			default: return 32'(int'($urandom_range(0, 40 * 65536)) - 20 * 65536);
		endcase
	endfunction

	function automatic logic [31:0] pick_dir();
		case ($urandom_range(0, 9))
			0: return 32'd0;
			1: return 32'hffff_ffff;
			2: return 32'd1;
			3: return $urandom();
			default: return 32'(int'($urandom_range(0, 8 * 65536)) - 4 * 65536);
		endcase
	endfunction

	// driver: the item on the bus stays at the queue front until accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			src_gap  <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid) void'(ray_q.pop_front());
			if (src_gap > 0 || ray_q.size() == 0 || quiet_src) begin
				s_tvalid <= 1'b0;
				if (src_gap > 0) src_gap <= src_gap - 1;
			end else begin
				s_tvalid <= 1'b1;
				s_tdata  <= ray_q[0];
				src_gap  <= quiet_snk ? 0 : pick_gap();
			end
		end
	end

	// predict on acceptance
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			isect_q.push_back(slab_isect(ray_t'(s_tdata)));
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		isect_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			snk_gap  <= 0;
			idle_cnt <= 0;
		end else begin
			if (snk_gap > 0) begin
				m_tready <= 1'b0;
				snk_gap  <= snk_gap - 1;
			end else begin
				m_tready <= 1'b1;
				if (!quiet_snk && $urandom_range(0, 3) == 0) snk_gap <= pick_gap();
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cnt <= 0;
			else idle_cnt <= idle_cnt + 1;
			if (m_tvalid && m_tready) begin
				if (isect_q.size() == 0) begin
					$error("unexpected result item %h", m_tdata);
					n_err++;
				end else begin
					want = isect_q.pop_front();
					if (m_tdata[0] !== want.hit) begin
						$error("hit: expected %0d, got %0d", want.hit, m_tdata[0]);
						n_err++;
					end
					if (m_tdata[32:1] !== want.t_entry) begin
						$error("t_entry: expected %h, got %h", want.t_entry, m_tdata[32:1]);
						n_err++;
					end
					if (m_tdata[64:33] !== want.t_exit) begin
						$error("t_exit: expected %h, got %h", want.t_exit, m_tdata[64:33]);
						n_err++;
					end
					if (m_tdata[71:65] !== 7'd0) begin
						$error("pad: expected 0, got %h", m_tdata[71:65]);
						n_err++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (idle_cnt >= IDLE_LIM) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic wait_drained();
		while (ray_q.size() > 0 || s_tvalid || isect_q.size() > 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		if (idx < REG_MAX_X) box_lo[idx] = longint'(signed'(val));
		else box_hi[idx - REG_MAX_X] = longint'(signed'(val));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_box(logic [31:0] lx, ly, lz, hx, hy, hz);
		write_reg(REG_MIN_X, lx);
		write_reg(REG_MIN_Y, ly);
		write_reg(REG_MIN_Z, lz);
		write_reg(REG_MAX_X, hx);
		write_reg(REG_MAX_Y, hy);
		write_reg(REG_MAX_Z, hz);
	endtask

	task automatic push_ray(logic [31:0] ox, oy, oz, dx, dy, dz);
		ray_t r;
		r = '{dz: dz, dy: dy, dx: dx, oz: oz, oy: oy, ox: ox};
		ray_q.push_back(r);
	endtask

	// a ray from a random origin aimed toward the middle of the box
	task automatic push_aimed();
		logic [31:0] o[3];
		logic [31:0] d[3];
		longint tgt;
		for (int i = 0; i < 3; i++) begin
			tgt  = box_lo[i] + (box_hi[i] - box_lo[i]) / 2;
			o[i] = pick_val();
			d[i] = clamp_q((tgt - longint'(signed'(o[i]))) / 4);
			if ($urandom_range(0, 9) == 0) d[i] = 32'd0;
		end
		push_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_addr  = REG_MIN_X;
		cfg_wdata = '0;
		quiet_snk = 1'b0;
		quiet_src = 1'b1;
		n_err     = 0;
		for (int i = 0; i < 3; i++) begin
			box_lo[i] = 0;
			box_hi[i] = 0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset box is a point at the origin
		push_ray(0, 0, 0, 0, 0, 0);
		push_ray(0, 0, 0, 32'h0001_0000, 32'hffff_0000, 32'h0000_0001);
		quiet_src = 1'b0;
		wait_drained();
		quiet_src = 1'b1;

		load_box(32'hffff_0000, 32'hffff_0000, 32'hffff_0000,
			32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
		push_ray(32'hfffb_0000, 0, 0, 32'h0001_0000, 0, 0);
		push_ray(0, 0, 32'h0005_0000, 0, 0, 32'hffff_0000);
		push_ray(0, 0, 0, 0, 0, 0);
		push_ray(32'h0002_0000, 0, 0, 0, 32'h0001_0000, 0);
		push_ray(32'hffff_0000, 32'hffff_0000, 0, 32'h0001_0000, 32'h0001_0000, 0);
		push_ray(32'hfffe_0000, 32'h0001_0000, 0, 32'h0001_0000, 32'h0001_0000, 0);
		push_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd1, 32'd1, 32'd1);
		push_ray(32'h7fff_ffff, 0, 0, 32'h8000_0000, 0, 0);
		push_ray(0, 0, 0, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000);
		push_ray(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		quiet_src = 1'b0;
		wait_drained();
		quiet_src = 1'b1;

		// reversed corners and extreme box
		load_box(32'h7fff_ffff, 32'h0003_0000, 32'h8000_0000,
			32'h8000_0000, 32'hfffd_0000, 32'h7fff_ffff);
		push_ray(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
		push_ray(0, 32'h0004_0000, 0, 32'h0001_0000, 0, 0);
		push_ray(32'h8000_0000, 0, 32'h7fff_ffff, 0, 32'hffff_ffff, 0);
		quiet_src = 1'b0;
		wait_drained();
		quiet_src = 1'b1;

		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 5)
				load_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
					32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
			else
				load_box(pick_val(), pick_val(), pick_val(),
					pick_val(), pick_val(), pick_val());
			quiet_snk = (ph == 2);
			for (int n = 0; n < 240; n++) begin
				if ($urandom_range(0, 2) != 0) push_aimed();
				else push_ray(pick_val(), pick_val(), pick_val(),
					pick_dir(), pick_dir(), pick_dir());
			end
			quiet_src = 1'b0;
			wait_drained();
			quiet_src = 1'b1;
		end
		quiet_snk = 1'b0;

		if (n_err == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
